### rtl/peu_pkg.sv
// Shared types, register codes and Q16.16 helper functions for the
// particle Euler update pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package peu_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_CENTER_MODE = 3'd3,
    REG_MAX_AGE     = 3'd4,
    REG_MAX_SPEED   = 3'd5
  } reg_idx_t;

  localparam logic [30:0] MAX_AGE_RST   = 31'd327680;
  localparam logic [30:0] MAX_SPEED_RST = 31'd655360;
  localparam logic [30:0] AGE_SAT       = 31'h7FFF_FFFF;
  localparam logic [31:0] S32_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN       = 32'h8000_0000;
  localparam int unsigned FAR_BIT       = 22;

  // one particle as it enters the block, carried to the end for dead items
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [30:0]      age;
    logic [16:0]      dt;
  } item_t;

  // sideband through the distance square root
  typedef struct packed {
    item_t            it;
    logic             far;
    logic [2:0]       dneg;
    logic [2:0][21:0] dlo;
  } ctag_t;

  // sideband through the x pull divider
  typedef struct packed {
    item_t      it;
    logic       far;
    logic [2:0] dneg;
    logic       sat;
  } cdtag_t;

  // sideband through the speed square root
  typedef struct packed {
    item_t            it;
    logic [2:0][31:0] vn;
    logic             clamp;
    logic [63:0]      s;
  } stag_t;

  // sideband through the x clamp divider
  typedef struct packed {
    item_t            it;
    logic [2:0][31:0] vn;
    logic             clamp;
  } vtag_t;

  function automatic logic [31:0] abs32(input logic [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  function automatic logic [31:0] sat32(input logic [33:0] x);
    if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
      return x[31:0];
    end
    return x[33] ? S32_MIN : S32_MAX;
  endfunction

  // |a| * dt >> 16, magnitude only
  function automatic logic [32:0] dt_mag(input logic [31:0] a, input logic [16:0] dt);
    logic [48:0] prod;
    prod = {17'd0, abs32(a)} * {32'd0, dt};
    return prod[48:16];
  endfunction

  // base +/- m, saturated to 32 bits signed
  function automatic logic [31:0] add_delta(input logic [31:0] base, input logic neg,
                                            input logic [32:0] m);
    logic [33:0] mx;
    logic [33:0] sum;
    mx  = {1'b0, m};
    sum = {{2{base[31]}}, base} + (neg ? (~mx + 34'd1) : mx);
    return sat32(sum);
  endfunction

endpackage

`default_nettype wire

### rtl/peu_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband
// tag that travels alongside. Standalone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module peu_isqrt #(
  parameter int W  = 64,
  parameter int TW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_vld,
  input  wire logic [W-1:0]    in_val,
  input  wire logic [TW-1:0]   in_tag,
  output logic                 out_vld,
  output logic [W/2-1:0]       out_root,
  output logic [TW-1:0]        out_tag
);

  localparam int H  = W / 2;
  localparam int RW = H + 2;

  logic            vld_r  [1:H];
  logic [RW-1:0]   rem_r  [1:H];
  logic [H-1:0]    root_r [1:H];
  logic [W-1:0]    rad_r  [1:H];
  logic [TW-1:0]   tag_r  [1:H];

  for (genvar k = 0; k < H; k++) begin : g_st
    logic            vld_c;
    logic [RW-1:0]   rem_c;
    logic [H-1:0]    root_c;
    logic [W-1:0]    rad_c;
    logic [TW-1:0]   tag_c;
    logic [RW-1:0]   rsh;
    logic [RW-1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_src
      assign vld_c  = in_vld;
      assign rem_c  = '0;
      assign root_c = '0;
      assign rad_c  = in_val;
      assign tag_c  = in_tag;
    end else begin : g_src
      assign vld_c  = vld_r[k];
      assign rem_c  = rem_r[k];
      assign root_c = root_r[k];
      assign rad_c  = rad_r[k];
      assign tag_c  = tag_r[k];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rsh   = {rem_c[H-1:0], rad_c[W-1 -: 2]};
    assign trial = {root_c, 2'b01};
    assign ge    = (rsh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= ge ? (rsh - trial) : rsh;
      root_r[k+1] <= {root_c[H-2:0], ge};
      rad_r[k+1]  <= rad_c << 2;
      tag_r[k+1]  <= tag_c;
    end
  end

  assign out_vld  = vld_r[H];
  assign out_root = root_r[H];
  assign out_tag  = tag_r[H];

endmodule

`default_nettype wire

### rtl/peu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// tag. Needs in_hi < in_den for a valid quotient. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module peu_div #(
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int TW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_vld,
  input  wire logic [DW-1:0]   in_hi,
  input  wire logic [QW-1:0]   in_lo,
  input  wire logic [DW-1:0]   in_den,
  input  wire logic [TW-1:0]   in_tag,
  output logic                 out_vld,
  output logic [QW-1:0]        out_quo,
  output logic [TW-1:0]        out_tag
);

  logic            vld_r [1:QW];
  logic [DW-1:0]   rem_r [1:QW];
  logic [QW-1:0]   lo_r  [1:QW];
  logic [DW-1:0]   den_r [1:QW];
  logic [TW-1:0]   tag_r [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic            vld_c;
    logic [DW-1:0]   rem_c;
    logic [QW-1:0]   lo_c;
    logic [DW-1:0]   den_c;
    logic [TW-1:0]   tag_c;
    logic [DW:0]     pw;
    logic [DW:0]     dif;
    logic            ge;

    if (k == 0) begin : g_src
      assign vld_c = in_vld;
      assign rem_c = in_hi;
      assign lo_c  = in_lo;
      assign den_c = in_den;
      assign tag_c = in_tag;
    end else begin : g_src
      assign vld_c = vld_r[k];
      assign rem_c = rem_r[k];
      assign lo_c  = lo_r[k];
      assign den_c = den_r[k];
      assign tag_c = tag_r[k];
    end

    assign pw  = {rem_c, lo_c[QW-1]};
    assign dif = pw - {1'b0, den_c};
    assign ge  = (pw >= {1'b0, den_c});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_c;
      end
    end

    // quotient bits shift in where numerator bits shift out
    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? dif[DW-1:0] : pw[DW-1:0];
      lo_r[k+1]  <= {lo_c[QW-2:0], ge};
      den_r[k+1] <= den_c;
      tag_r[k+1] <= tag_c;
    end
  end

  assign out_vld = vld_r[QW];
  assign out_quo = lo_r[QW];
  assign out_tag = tag_r[QW];

endmodule

`default_nettype wire

### rtl/particle_euler_update_unit.sv
// Particle Euler update, top level: config registers and the full pipeline.
// Uses peu_pkg, peu_isqrt and peu_div.
//
// Usage:
//   Input: drive the particle fields and pulse start; an item transfers on
//   every clock edge with start high and busy low. busy stays low, so one
//   particle can enter on every cycle.
//   Output: out_valid is high for exactly one cycle with the updated fields.
//   Results leave in input order.
//   The pipeline holds the two square roots (23 and 32 stages) and the two
//   divider banks (31 and 32 stages), one bit per stage each.
//   Throughput: one particle per cycle, sustained.
//   Config: cfg_valid/cfg_index/cfg_data, cfg_ready always high. Write only
//   with no particle in flight.
//   Reset (rst_n low, synchronous) restores register defaults and drops
//   every particle in flight.
//   The receiver has no back pressure: results must be taken when shown.
`timescale 1ns / 1ps
`default_nettype none

module particle_euler_update_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [31:0] in_vel_x,
  input  wire logic [31:0] in_vel_y,
  input  wire logic [31:0] in_vel_z,
  input  wire logic [30:0] in_age,
  input  wire logic [16:0] in_dt,
  output logic             out_valid,
  output logic [31:0]      out_new_pos_x,
  output logic [31:0]      out_new_pos_y,
  output logic [31:0]      out_new_pos_z,
  output logic [31:0]      out_new_vel_x,
  output logic [31:0]      out_new_vel_y,
  output logic [31:0]      out_new_vel_z,
  output logic [30:0]      out_new_age,
  output logic             out_was_alive,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  import peu_pkg::*;

  // ---------------- configuration ----------------
  logic [31:0] cx_r, cy_r, cz_r;
  logic        center_mode_r;
  logic [30:0] max_age_r, max_speed_r;
  logic [61:0] msq_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r          <= '0;
      cy_r          <= '0;
      cz_r          <= '0;
      center_mode_r <= 1'b0;
      max_age_r     <= MAX_AGE_RST;
      max_speed_r   <= MAX_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CENTER_X:    cx_r          <= cfg_data;
        REG_CENTER_Y:    cy_r          <= cfg_data;
        REG_CENTER_Z:    cz_r          <= cfg_data;
        REG_CENTER_MODE: center_mode_r <= cfg_data[0];
        REG_MAX_AGE:     max_age_r     <= cfg_data[30:0];
        REG_MAX_SPEED:   max_speed_r   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    msq_r <= {31'd0, max_speed_r} * {31'd0, max_speed_r};
  end

  // ---------------- s0: input register ----------------
  logic  vld0_r;
  item_t it0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else        vld0_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    it0_r.pos <= {in_pos_z, in_pos_y, in_pos_x};
    it0_r.vel <= {in_vel_z, in_vel_y, in_vel_x};
    it0_r.age <= in_age;
    it0_r.dt  <= in_dt;
  end

  // ---------------- s1: distance to center ----------------
  logic             vld1_r;
  item_t            it1_r;
  logic [2:0][32:0] dabs1_r;
  logic [2:0]       dneg1_r;
  logic [2:0][31:0] ctr;

  assign ctr = {cz_r, cy_r, cx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else        vld1_r <= vld0_r;
  end

  always_ff @(posedge clk) begin
    logic [32:0] d;
    it1_r <= it0_r;
    for (int i = 0; i < 3; i++) begin
      d          = {ctr[i][31], ctr[i]} - {it0_r.pos[i][31], it0_r.pos[i]};
      dneg1_r[i] <= d[32];
      dabs1_r[i] <= d[32] ? (~d + 33'd1) : d;
    end
  end

  // ---------------- s2: squares ----------------
  logic             vld2_r;
  ctag_t            ct2_r;
  logic [2:0][43:0] sq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld2_r <= 1'b0;
    else        vld2_r <= vld1_r;
  end

  always_ff @(posedge clk) begin
    ct2_r.it   <= it1_r;
    ct2_r.dneg <= dneg1_r;
    ct2_r.far  <= (|dabs1_r[0][32:FAR_BIT]) || (|dabs1_r[1][32:FAR_BIT]) ||
                  (|dabs1_r[2][32:FAR_BIT]);
    for (int i = 0; i < 3; i++) begin
      ct2_r.dlo[i] <= dabs1_r[i][21:0];
      sq2_r[i]     <= {22'd0, dabs1_r[i][21:0]} * {22'd0, dabs1_r[i][21:0]};
    end
  end

  // ---------------- s3: sum of squares ----------------
  logic        vld3_r;
  ctag_t       ct3_r;
  logic [45:0] s46_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld3_r <= 1'b0;
    else        vld3_r <= vld2_r;
  end

  always_ff @(posedge clk) begin
    ct3_r <= ct2_r;
    s46_r <= {2'd0, sq2_r[0]} + {2'd0, sq2_r[1]} + {2'd0, sq2_r[2]};
  end

  logic        cq_vld;
  logic [22:0] cq_root;
  ctag_t       cq_tag;

  peu_isqrt #(.W(46), .TW($bits(ctag_t))) u_sqrt_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld3_r),
    .in_val   (s46_r),
    .in_tag   (ct3_r),
    .out_vld  (cq_vld),
    .out_root (cq_root),
    .out_tag  (cq_tag)
  );

  // ---------------- s4..s6: r^4 ----------------
  logic        vld4_r, vld5_r, vld6_r;
  ctag_t       ct4_r, ct5_r, ct6_r;
  logic [45:0] r2_4_r;
  logic [45:0] hh5_r, hl5_r, ll5_r;
  logic [91:0] r4_6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else begin
      vld4_r <= cq_vld;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [22:0] r;
    // r floored at one LSB for a particle sitting on the center
    r      = (cq_root == '0) ? 23'd1 : cq_root;
    ct4_r  <= cq_tag;
    r2_4_r <= {23'd0, r} * {23'd0, r};
    ct5_r  <= ct4_r;
    hh5_r  <= {23'd0, r2_4_r[45:23]} * {23'd0, r2_4_r[45:23]};
    hl5_r  <= {23'd0, r2_4_r[45:23]} * {23'd0, r2_4_r[22:0]};
    ll5_r  <= {23'd0, r2_4_r[22:0]} * {23'd0, r2_4_r[22:0]};
    ct6_r  <= ct5_r;
    // (h*2^23 + l)^2 = hh*2^46 + hl*2^24 + ll
    r4_6_r <= {hh5_r, 46'd0} + {22'd0, hl5_r, 24'd0} + {46'd0, ll5_r};
  end

  // ---------------- pull dividers ----------------
  logic [2:0][91:0] cnum;
  logic [2:0]       csat;
  cdtag_t           cd_in_tag, cd_tag;
  logic [2:0][30:0] cquo;
  logic             cd_vld;
  logic             csat_y, csat_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cnum[i] = {37'd0, ct6_r.dlo[i], 33'd0};
      csat[i] = (cnum[i] >= r4_6_r);
    end
    cd_in_tag.it   = ct6_r.it;
    cd_in_tag.far  = ct6_r.far;
    cd_in_tag.dneg = ct6_r.dneg;
    cd_in_tag.sat  = csat[0];
  end

  peu_div #(.DW(92), .QW(31), .TW($bits(cdtag_t))) u_div_pull_x (
    .clk (clk), .rst_n (rst_n), .in_vld (vld6_r), .in_hi (cnum[0]), .in_lo ('0),
    .in_den (r4_6_r), .in_tag (cd_in_tag),
    .out_vld (cd_vld), .out_quo (cquo[0]), .out_tag (cd_tag)
  );

  peu_div #(.DW(92), .QW(31), .TW(1)) u_div_pull_y (
    .clk (clk), .rst_n (rst_n), .in_vld (vld6_r), .in_hi (cnum[1]), .in_lo ('0),
    .in_den (r4_6_r), .in_tag (csat[1]),
    .out_vld (), .out_quo (cquo[1]), .out_tag (csat_y)
  );

  peu_div #(.DW(92), .QW(31), .TW(1)) u_div_pull_z (
    .clk (clk), .rst_n (rst_n), .in_vld (vld6_r), .in_hi (cnum[2]), .in_lo ('0),
    .in_den (r4_6_r), .in_tag (csat[2]),
    .out_vld (), .out_quo (cquo[2]), .out_tag (csat_z)
  );

  // ---------------- a1..a5: velocity update and speed^2 ----------------
  logic             vld_a1_r, vld_a2_r, vld_a3_r, vld_a4_r, vld_a5_r;
  item_t            it_a1_r, it_a2_r, it_a3_r, it_a4_r, it_a5_r;
  logic [2:0][31:0] acc_a1_r;
  logic [2:0][32:0] m_a2_r;
  logic [2:0]       neg_a2_r;
  logic [2:0][31:0] vn_a3_r, vn_a4_r, vn_a5_r;
  logic [2:0][63:0] sq_a4_r;
  logic [63:0]      s64_a5_r;
  logic [2:0]       csat_all;

  assign csat_all = {csat_z, csat_y, cd_tag.sat};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a1_r <= 1'b0;
      vld_a2_r <= 1'b0;
      vld_a3_r <= 1'b0;
      vld_a4_r <= 1'b0;
      vld_a5_r <= 1'b0;
    end else begin
      vld_a1_r <= cd_vld;
      vld_a2_r <= vld_a1_r;
      vld_a3_r <= vld_a2_r;
      vld_a4_r <= vld_a3_r;
      vld_a5_r <= vld_a4_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] a_c, a_s, p;
    it_a1_r <= cd_tag.it;
    for (int i = 0; i < 3; i++) begin
      p = cd_tag.it.pos[i];
      a_s = (p == S32_MIN) ? S32_MAX : (~p + 32'd1);
      if (cd_tag.far) begin
        a_c = '0;
      end else if (csat_all[i]) begin
        a_c = cd_tag.dneg[i] ? S32_MIN : S32_MAX;
      end else begin
        a_c = cd_tag.dneg[i] ? (~{1'b0, cquo[i]} + 32'd1) : {1'b0, cquo[i]};
      end
      acc_a1_r[i] <= center_mode_r ? a_c : a_s;
    end

    it_a2_r <= it_a1_r;
    for (int i = 0; i < 3; i++) begin
      m_a2_r[i]   <= dt_mag(acc_a1_r[i], it_a1_r.dt);
      neg_a2_r[i] <= acc_a1_r[i][31];
    end

    it_a3_r <= it_a2_r;
    for (int i = 0; i < 3; i++) begin
      vn_a3_r[i] <= add_delta(it_a2_r.vel[i], neg_a2_r[i], m_a2_r[i]);
    end

    it_a4_r <= it_a3_r;
    vn_a4_r <= vn_a3_r;
    for (int i = 0; i < 3; i++) begin
      sq_a4_r[i] <= {32'd0, abs32(vn_a3_r[i])} * {32'd0, abs32(vn_a3_r[i])};
    end

    it_a5_r  <= it_a4_r;
    vn_a5_r  <= vn_a4_r;
    s64_a5_r <= sq_a4_r[0] + sq_a4_r[1] + sq_a4_r[2];
  end

  stag_t       sq_in_tag, sq_tag;
  logic        sq_vld;
  logic [31:0] sq_root;

  always_comb begin
    sq_in_tag.it    = it_a5_r;
    sq_in_tag.vn    = vn_a5_r;
    sq_in_tag.clamp = (s64_a5_r > {2'd0, msq_r});
    sq_in_tag.s     = s64_a5_r;
  end

  peu_isqrt #(.W(64), .TW($bits(stag_t))) u_sqrt_speed (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_a5_r),
    .in_val   (s64_a5_r),
    .in_tag   (sq_in_tag),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  // ---------------- b1, b2: ceil(sqrt) and clamp numerators ----------------
  logic             vld_b1_r, vld_b2_r;
  stag_t            st_b1_r;
  logic [31:0]      root_b1_r;
  logic [63:0]      rr_b1_r;
  logic [2:0][31:0] vabs_b1_r;
  vtag_t            vt_b2_r;
  logic [31:0]      c_b2_r;
  logic [2:0][62:0] n_b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b1_r <= 1'b0;
      vld_b2_r <= 1'b0;
    end else begin
      vld_b1_r <= sq_vld;
      vld_b2_r <= vld_b1_r;
    end
  end

  always_ff @(posedge clk) begin
    st_b1_r   <= sq_tag;
    root_b1_r <= sq_root;
    rr_b1_r   <= {32'd0, sq_root} * {32'd0, sq_root};
    for (int i = 0; i < 3; i++) begin
      vabs_b1_r[i] <= abs32(sq_tag.vn[i]);
    end

    vt_b2_r.it    <= st_b1_r.it;
    vt_b2_r.vn    <= st_b1_r.vn;
    vt_b2_r.clamp <= st_b1_r.clamp;
    c_b2_r        <= root_b1_r + {31'd0, (rr_b1_r < st_b1_r.s)};
    for (int i = 0; i < 3; i++) begin
      n_b2_r[i] <= {31'd0, vabs_b1_r[i]} * {32'd0, max_speed_r};
    end
  end

  vtag_t            vd_tag;
  logic             vd_vld;
  logic             vd_vld_y;
  logic [2:0][31:0] vquo;

  peu_div #(.DW(32), .QW(32), .TW($bits(vtag_t))) u_div_clamp_x (
    .clk (clk), .rst_n (rst_n), .in_vld (vld_b2_r), .in_hi ({1'b0, n_b2_r[0][62:32]}),
    .in_lo (n_b2_r[0][31:0]), .in_den (c_b2_r), .in_tag (vt_b2_r),
    .out_vld (vd_vld), .out_quo (vquo[0]), .out_tag (vd_tag)
  );

  peu_div #(.DW(32), .QW(32), .TW(1)) u_div_clamp_y (
    .clk (clk), .rst_n (rst_n), .in_vld (vld_b2_r), .in_hi ({1'b0, n_b2_r[1][62:32]}),
    .in_lo (n_b2_r[1][31:0]), .in_den (c_b2_r), .in_tag (1'b0),
    .out_vld (vd_vld_y), .out_quo (vquo[1]), .out_tag ()
  );

  peu_div #(.DW(32), .QW(32), .TW(1)) u_div_clamp_z (
    .clk (clk), .rst_n (rst_n), .in_vld (vld_b2_r), .in_hi ({1'b0, n_b2_r[2][62:32]}),
    .in_lo (n_b2_r[2][31:0]), .in_den (c_b2_r), .in_tag (1'b0),
    .out_vld (), .out_quo (vquo[2]), .out_tag ()
  );

  // ---------------- b3, b4, output: position update ----------------
  logic             vld_b3_r, vld_b4_r, out_valid_r;
  item_t            it_b3_r, it_b4_r;
  logic [2:0][31:0] vf_b3_r, vf_b4_r;
  logic [2:0][32:0] m_b4_r;
  logic [2:0][31:0] pos_o_r, vel_o_r;
  logic [30:0]      age_o_r;
  logic             alive_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b3_r    <= 1'b0;
      vld_b4_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_b3_r    <= vd_vld;
      vld_b4_r    <= vld_b3_r;
      out_valid_r <= vld_b4_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] na;
    logic        alive;
    it_b3_r <= vd_tag.it;
    for (int i = 0; i < 3; i++) begin
      if (vd_tag.clamp) begin
        vf_b3_r[i] <= vd_tag.vn[i][31] ? (~vquo[i] + 32'd1) : vquo[i];
      end else begin
        vf_b3_r[i] <= vd_tag.vn[i];
      end
    end

    it_b4_r <= it_b3_r;
    vf_b4_r <= vf_b3_r;
    for (int i = 0; i < 3; i++) begin
      m_b4_r[i] <= dt_mag(vf_b3_r[i], it_b3_r.dt);
    end

    alive = (it_b4_r.age <= max_age_r);
    na    = {1'b0, it_b4_r.age} + {15'd0, it_b4_r.dt};
    alive_o_r <= alive;
    if (alive) begin
      age_o_r <= na[31] ? AGE_SAT : na[30:0];
      vel_o_r <= vf_b4_r;
      for (int i = 0; i < 3; i++) begin
        pos_o_r[i] <= add_delta(it_b4_r.pos[i], vf_b4_r[i][31], m_b4_r[i]);
      end
    end else begin
      age_o_r <= it_b4_r.age;
      vel_o_r <= it_b4_r.vel;
      pos_o_r <= it_b4_r.pos;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_pos_x = pos_o_r[0];
  assign out_new_pos_y = pos_o_r[1];
  assign out_new_pos_z = pos_o_r[2];
  assign out_new_vel_x = vel_o_r[0];
  assign out_new_vel_y = vel_o_r[1];
  assign out_new_vel_z = vel_o_r[2];
  assign out_new_age   = age_o_r;
  assign out_was_alive = alive_o_r;

  // ---------------- checks ----------------
  a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    vld_b1_r |-> (rr_b1_r <= st_b1_r.s))
    else $error("speed root squared exceeds radicand");

  a_clamp_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    vd_vld == vd_vld_y)
    else $error("clamp divider lanes out of step");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vd_vld, 3))
    else $error("result strobe without a transfer from the clamp dividers");

endmodule

`default_nettype wire
